/* rtl/lcg48_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_pkg
// Shared types and constants of the 48-bit linear congruential generator.
// ----------------------------------------------------------------------------
package lcg48_pkg;

	// generator constants
	localparam int unsigned LCG_BITS  = 48;
	localparam int unsigned DRAW_BITS = 31;
	localparam int unsigned MULT_BITS = 35;
	localparam logic [MULT_BITS-1:0] LCG_MULT = 35'h5_DEEC_E66D;
	localparam logic [LCG_BITS-1:0]  LCG_INC  = 48'hB;

	// payload widths
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned SEED_W  = 64;
	localparam int unsigned BITS_W  = 6;
	localparam int unsigned BOUND_W = 32;
	localparam int unsigned VALUE_W = 32;

	// shared unit operand widths
	localparam int unsigned ACC_W   = 64;
	localparam int unsigned CHUNK_W = 16;
	localparam int unsigned REM_W   = DRAW_BITS;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_RESEED  = 2'd0,
		CMD_RAW     = 2'd1,
		CMD_BOUNDED = 2'd2
	} cmd_t;

	// shared unit operations
	typedef enum logic {
		ALU_MAC = 1'b0,
		ALU_DIV = 1'b1
	} alu_op_t;

	// draw modes
	typedef enum logic [1:0] {
		MODE_RAW  = 2'd0,
		MODE_POW2 = 2'd1,
		MODE_MOD  = 2'd2
	} mode_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_ADV      = 3'd1,
		ST_DISPATCH = 3'd2,
		ST_SCALE    = 3'd3,
		ST_DIV      = 3'd4,
		ST_CHECK    = 3'd5,
		ST_OUT      = 3'd6
	} state_t;

	// request to the shared unit
	typedef struct packed {
		alu_op_t              op;
		logic [ACC_W-1:0]     acc;
		logic [CHUNK_W-1:0]   mul_a;
		logic [MULT_BITS-1:0] mul_b;
		logic [1:0]           sel;
		logic [REM_W-1:0]     rem;
		logic                 div_bit;
		logic [REM_W-1:0]     divisor;
	} alu_req_t;

	// response of the shared unit
	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic [REM_W-1:0] rem;
	} alu_rsp_t;

endpackage

/* rtl/lcg48_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_req_if
// Command channel: valid, ready and one command item.
// ----------------------------------------------------------------------------
interface lcg48_req_if import lcg48_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic signed [SEED_W-1:0]  seed_value;
	logic [BITS_W-1:0]         bit_count;
	logic signed [BOUND_W-1:0] upper_bound;

	modport source (output valid, command, seed_value, bit_count, upper_bound, input ready);
	modport sink (input valid, command, seed_value, bit_count, upper_bound, output ready);
endinterface

/* rtl/lcg48_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_rsp_if
// Result channel: valid, ready and one drawn value.
// ----------------------------------------------------------------------------
interface lcg48_rsp_if import lcg48_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] random_value;

	modport source (output valid, random_value, input ready);
	modport sink (input valid, random_value, output ready);
endinterface

/* rtl/lcg48_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_alu
// Shared arithmetic unit: 16 x 35 multiply-accumulate with chunk shift, or
// one restoring division step.
// ----------------------------------------------------------------------------
module lcg48_alu import lcg48_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam int unsigned PROD_W = CHUNK_W + MULT_BITS;

	logic [PROD_W-1:0] prod;
	logic [ACC_W-1:0]  prod_ext;
	logic [ACC_W-1:0]  mac_acc;
	logic [REM_W:0]    trial;
	logic [REM_W:0]    diff;
	logic [REM_W-1:0]  div_rem;

	// multiply one chunk and add it at its place
	assign prod     = req.mul_a * req.mul_b;
	assign prod_ext = {{(ACC_W-PROD_W){1'b0}}, prod} << {req.sel, 4'b0000};
	assign mac_acc  = req.acc + prod_ext;

	// shift in one dividend bit, subtract when the divisor fits
	assign trial   = {req.rem, req.div_bit};
	assign diff    = trial - {1'b0, req.divisor};
	assign div_rem = (trial >= {1'b0, req.divisor}) ? diff[REM_W-1:0] : trial[REM_W-1:0];

	// select by operation
	always_comb begin
		rsp.acc = req.acc;
		rsp.rem = req.rem;
		case (req.op)
			ALU_MAC: rsp.acc = mac_acc;
			ALU_DIV: rsp.rem = div_rem;
			default: rsp.acc = req.acc;
		endcase
	end

endmodule

/* rtl/lcg48_random_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_random_generator
// 48-bit linear congruential generator with raw and bounded draws.
// ----------------------------------------------------------------------------
// One command item is taken at a time; ready is low while it is worked on.
// A reseed gives no result. Each advance of the state runs three
// multiply-accumulate passes of the shared 16 x 35 unit over the state.
// A raw draw takes the top bits of the new state; a bounded draw with a
// power-of-two bound scales the draw in the same unit, and a bounded draw with
// any other bound runs an advance, 31 restoring division steps in the same
// unit and one rejection check, and advances again for each rejected draw.
// A bound of zero or less answers 0. The result sits in an output register
// until taken; the next command is accepted once that result has been loaded.
// ----------------------------------------------------------------------------
module lcg48_random_generator import lcg48_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	lcg48_req_if.sink    req,
	lcg48_rsp_if.source  rsp
);

	localparam logic [LCG_BITS-1:0] MULT48 = {{(LCG_BITS-MULT_BITS){1'b0}}, LCG_MULT};
	localparam logic [4:0] DIV_LAST = 5'(DRAW_BITS - 1);

	state_t               state_q, state_d;
	mode_t                mode_q;
	logic [LCG_BITS-1:0]  lcg_q;
	logic [ACC_W-1:0]     acc_q;
	logic [REM_W-1:0]     rem_q;
	logic [REM_W-1:0]     bound_q;
	logic [BITS_W-1:0]    bits_q;
	logic [4:0]           cnt_q;
	logic [VALUE_W-1:0]   result_q;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   out_data_q;

	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;
	logic                 accept;
	logic                 bound_nonpos;
	logic                 bound_pow2;
	logic [BOUND_W-1:0]   bound_dec;
	logic [DRAW_BITS-1:0] draw31;
	logic [BOUND_W-1:0]   bound32;
	logic [BITS_W-1:0]    bits_sat;
	logic [BITS_W-1:0]    shamt;
	logic [VALUE_W-1:0]   raw_value;
	logic [32:0]          bucket_top;
	logic                 reject;
	logic                 slot_free;

	lcg48_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// handshake and command decode
	assign req.ready    = (state_q == ST_IDLE);
	assign accept       = req.valid && req.ready;
	assign bound_dec    = req.upper_bound - BOUND_W'(1);
	assign bound_nonpos = req.upper_bound[BOUND_W-1] || (req.upper_bound == '0);
	assign bound_pow2   = ((req.upper_bound & bound_dec) == '0);

	// current draw and raw top bits
	assign draw31    = lcg_q[LCG_BITS-1 -: DRAW_BITS];
	assign bound32   = {1'b0, bound_q};
	assign bits_sat  = (bits_q > BITS_W'(VALUE_W)) ? BITS_W'(VALUE_W) : bits_q;
	assign shamt     = BITS_W'(VALUE_W) - bits_sat;
	assign raw_value = (bits_q == '0) ? '0 : (lcg_q[LCG_BITS-1 -: VALUE_W] >> shamt);

	// rejection of draws whose bucket overflows
	assign bucket_top = {2'b00, draw31} - {2'b00, rem_q} + {2'b00, bound_q} - 33'd1;
	assign reject     = (bucket_top > 33'h0_7FFF_FFFF);

	assign slot_free = !out_valid_q || rsp.ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and shared unit control
	always_comb begin
		state_d         = state_q;
		alu_req.op      = ALU_MAC;
		alu_req.acc     = acc_q;
		alu_req.mul_a   = '0;
		alu_req.mul_b   = '0;
		alu_req.sel     = cnt_q[1:0];
		alu_req.rem     = rem_q;
		alu_req.div_bit = 1'b0;
		alu_req.divisor = bound_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(req.command))
						CMD_RAW:     state_d = ST_ADV;
						CMD_BOUNDED: state_d = bound_nonpos ? ST_OUT : ST_ADV;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADV: begin
				alu_req.acc   = (cnt_q == '0) ? {{(ACC_W-LCG_BITS){1'b0}}, LCG_INC} : acc_q;
				alu_req.mul_a = lcg_q[{cnt_q[1:0], 4'b0000} +: CHUNK_W];
				alu_req.mul_b = LCG_MULT;
				if (cnt_q == 5'd2) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (mode_q)
					MODE_RAW:  state_d = ST_OUT;
					MODE_POW2: state_d = ST_SCALE;
					default:   state_d = ST_DIV;
				endcase
			end
			ST_SCALE: begin
				alu_req.acc   = (cnt_q == '0) ? '0 : acc_q;
				alu_req.mul_a = bound32[{cnt_q[0], 4'b0000} +: CHUNK_W];
				alu_req.mul_b = {{(MULT_BITS-DRAW_BITS){1'b0}}, draw31};
				if (cnt_q == 5'd1) begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				alu_req.op      = ALU_DIV;
				alu_req.div_bit = draw31[cnt_q];
				if (cnt_q == '0) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = reject ? ST_ADV : ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= MULT48;
		end else if (accept && (cmd_t'(req.command) == CMD_RESEED)) begin
			lcg_q <= req.seed_value[LCG_BITS-1:0] ^ MULT48;
		end else if ((state_q == ST_ADV) && (cnt_q == 5'd2)) begin
			lcg_q <= alu_rsp.acc[LCG_BITS-1:0];
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE:     cnt_q <= '0;
				ST_ADV:      cnt_q <= (cnt_q == 5'd2) ? '0 : cnt_q + 5'd1;
				ST_DISPATCH: cnt_q <= (mode_q == MODE_MOD) ? DIV_LAST : '0;
				ST_SCALE:    cnt_q <= cnt_q + 5'd1;
				ST_DIV:      cnt_q <= cnt_q - 5'd1;
				ST_CHECK:    cnt_q <= '0;
				default:     cnt_q <= '0;
			endcase
		end
	end

	// draw mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RAW;
		end else if (accept) begin
			if (cmd_t'(req.command) == CMD_BOUNDED) begin
				mode_q <= bound_pow2 ? MODE_POW2 : MODE_MOD;
			end else begin
				mode_q <= MODE_RAW;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					bits_q   <= req.bit_count;
					bound_q  <= req.upper_bound[REM_W-1:0];
					result_q <= '0;
				end
			end
			ST_ADV: begin
				acc_q <= alu_rsp.acc;
			end
			ST_DISPATCH: begin
				rem_q <= '0;
				if (mode_q == MODE_RAW) begin
					result_q <= raw_value;
				end
			end
			ST_SCALE: begin
				acc_q <= alu_rsp.acc;
				if (cnt_q == 5'd1) begin
					result_q <= alu_rsp.acc[62:31];
				end
			end
			ST_DIV: begin
				rem_q <= alu_rsp.rem;
			end
			ST_CHECK: begin
				if (!reject) begin
					result_q <= {1'b0, rem_q};
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && slot_free) begin
			out_data_q <= result_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.random_value = out_data_q;

endmodule
